FILE: sv/gcai_pkg.sv
`default_nettype none
package gcai_pkg;

  // Fixed-point format and field widths
  localparam int FRAC_BITS = 14;
  localparam int CW        = 16;             // coordinate width
  localparam int QOW       = FRAC_BITS + 2;  // normalized component width
  localparam int PW        = 19;             // raw cross product width
  localparam int XW        = 2 * CW + 2;     // exact cross difference width
  localparam int DOTW      = 2 * CW + 2;     // exact dot product width
  localparam int EPS_W     = 14;

  localparam logic [EPS_W-1:0] EPS_RESET = 14'd2;

  // Configuration port
  localparam int         ADDR_W      = 3;
  localparam logic [0:0] REG_EPSILON = 1'b0;

  // Pipeline depths
  localparam int NORM_LAT_C = CW + 3;
  localparam int NORM_LAT_P = PW + 3;
  localparam int DIV_LAT    = FRAC_BITS + 3;
  localparam int CROSS_LAT  = 2;
  localparam int SEL_LAT    = 1;
  localparam int ARC_LAT    = NORM_LAT_C + DIV_LAT + SEL_LAT + CROSS_LAT + NORM_LAT_P + DIV_LAT;
  localparam int CXF_LAT    = 3;
  localparam int SGN_LAT    = 2;
  localparam int TOP_LAT    = ARC_LAT + CROSS_LAT + NORM_LAT_P + DIV_LAT + SGN_LAT + 1;

  typedef logic [2:0][CW-1:0] vec_t;
  typedef logic [2:0][PW-1:0] pvec_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_COLLINEAR = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CW-1:0] a_tail_x;
    logic signed [CW-1:0] a_tail_y;
    logic signed [CW-1:0] a_tail_z;
    logic signed [CW-1:0] a_head_x;
    logic signed [CW-1:0] a_head_y;
    logic signed [CW-1:0] a_head_z;
    logic signed [CW-1:0] b_tail_x;
    logic signed [CW-1:0] b_tail_y;
    logic signed [CW-1:0] b_tail_z;
    logic signed [CW-1:0] b_head_x;
    logic signed [CW-1:0] b_head_y;
    logic signed [CW-1:0] b_head_z;
  } req_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    status_t              status;
    logic                 arcs_cross;
  } rsp_t;

  localparam logic [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);

  // Shift right by FRAC_BITS, round to nearest, halves away from zero
  function automatic logic signed [XW-1:0] rnd_shr(input logic signed [XW-1:0] v);
    logic [XW-1:0] m;
    logic [XW-1:0] r;
    m = v[XW-1] ? $unsigned(-v) : $unsigned(v);
    r = (m + HALF) >> FRAC_BITS;
    return v[XW-1] ? $signed(-r) : $signed(r);
  endfunction

  // True when the two values have strictly opposite signs
  function automatic logic opp(input logic signed [DOTW-1:0] a,
                               input logic signed [DOTW-1:0] b);
    return (a < 0 && b > 0) || (a > 0 && b < 0);
  endfunction

endpackage
`default_nettype wire

FILE: sv/gcai_dly.sv
`default_nettype none
module gcai_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe [0:N-1];

  // Advance the line when the pipeline moves
  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= d;
      for (int i = 1; i < N; i++) begin
        pipe[i] <= pipe[i-1];
      end
    end
  end

  assign q = pipe[N-1];

endmodule
`default_nettype wire

FILE: sv/gcai_norm.sv
`default_nettype none
module gcai_norm #(
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [2:0][CW-1:0]   v,
  output logic [CW:0]          norm
);

  localparam int SQ  = 2 * CW;
  localparam int RW  = CW + 1;
  localparam int SW  = 2 * RW;
  localparam int RMW = RW + 2;
  localparam int XRW = RW + 4;

  logic [SW-1:0]  sq [0:2];
  logic [SW-1:0]  sum;
  logic [SW-1:0]  s_q    [0:RW-2];
  logic [RMW-1:0] rem_q  [0:RW-2];
  logic [RW-1:0]  root_q [0:RW-1];

  // Square each component
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SW'($unsigned(SQ'($signed(v[i])) * SQ'($signed(v[i]))));
      end
    end
  end

  // Sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= sq[0] + sq[1] + sq[2];
    end
  end

  // Integer square root, one result bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [SW-1:0]  s_in;
    logic [RMW-1:0] rem_in;
    logic [RW-1:0]  root_in;
    logic [XRW-1:0] remx;
    logic [XRW-1:0] trial;

    if (k == 0) begin : g_first
      assign s_in    = sum;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign s_in    = s_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign remx  = {rem_in, s_in[SW-1 -: 2]};
    assign trial = XRW'({root_in, 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        if (remx >= trial) begin
          root_q[k] <= {root_in[RW-2:0], 1'b1};
        end else begin
          root_q[k] <= {root_in[RW-2:0], 1'b0};
        end
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          s_q[k] <= s_in << 2;
          if (remx >= trial) begin
            rem_q[k] <= RMW'(remx - trial);
          end else begin
            rem_q[k] <= RMW'(remx);
          end
        end
      end
    end
  end

  assign norm = root_q[RW-1];

endmodule
`default_nettype wire

FILE: sv/gcai_div.sv
`default_nettype none
module gcai_div #(
  parameter int NW = 16,
  parameter int DW = 17
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [NW-1:0]              num,
  input  logic        [DW-1:0]              den,
  output logic signed [gcai_pkg::QOW-1:0]   quo
);

  localparam int FB = gcai_pkg::FRAC_BITS;
  localparam int QW = FB + 1;
  localparam int RW = ((NW + FB > DW + QW) ? NW + FB : DW + QW) + 1;

  logic [NW-1:0] mag;
  logic [RW-1:0] rem_q [0:QW-1];
  logic [DW-1:0] den_q [0:QW-1];
  logic          neg_q [0:QW];
  logic [QW-1:0] quo_q [0:QW];

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);

  // Scale the magnitude and add half the divisor for rounding
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= (RW'(mag) << FB) + RW'(den >> 1);
      den_q[0] <= den;
      neg_q[0] <= num[NW-1];
      quo_q[0] <= '0;
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int BIT = QW - 1 - k;
    logic [RW-1:0] dsh;
    logic          take;

    assign dsh  = RW'(den_q[k]) << BIT;
    assign take = rem_q[k] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_q[k+1] <= take ? (quo_q[k] | (QW'(1) << BIT)) : quo_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k+1] <= take ? rem_q[k] - dsh : rem_q[k];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  // Restore the sign
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg_q[QW] ? -$signed({1'b0, quo_q[QW]}) : $signed({1'b0, quo_q[QW]});
    end
  end

endmodule
`default_nettype wire

FILE: sv/gcai_cross.sv
`default_nettype none
module gcai_cross (
  input  logic            clk,
  input  logic            en,
  input  gcai_pkg::vec_t  a,
  input  gcai_pkg::vec_t  b,
  output gcai_pkg::pvec_t p
);

  localparam int CW = gcai_pkg::CW;
  localparam int SQ = 2 * CW;
  localparam int XW = gcai_pkg::XW;
  localparam int PW = gcai_pkg::PW;
  localparam int NXT [0:2] = '{1, 2, 0};
  localparam int NNX [0:2] = '{2, 0, 1};

  logic signed [SQ-1:0] m_pos [0:2];
  logic signed [SQ-1:0] m_neg [0:2];

  // Partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_pos[i] <= SQ'($signed(a[NXT[i]])) * SQ'($signed(b[NNX[i]]));
        m_neg[i] <= SQ'($signed(a[NNX[i]])) * SQ'($signed(b[NXT[i]]));
      end
    end
  end

  // Difference, rescaled back to FRAC_BITS
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p[i] <= PW'(gcai_pkg::rnd_shr(XW'(m_pos[i]) - XW'(m_neg[i])));
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/gcai_arc.sv
`default_nettype none
module gcai_arc (
  input  logic                          clk,
  input  logic                          en,
  input  logic [gcai_pkg::EPS_W-1:0]    eps,
  input  gcai_pkg::vec_t                tail,
  input  gcai_pkg::vec_t                head,
  output gcai_pkg::vec_t                tail_unit,
  output gcai_pkg::vec_t                head_unit,
  output gcai_pkg::vec_t                pole,
  output logic                          bad
);

  localparam int CW   = gcai_pkg::CW;
  localparam int PW   = gcai_pkg::PW;
  localparam int NW1  = CW + 1;
  localparam int PW1  = PW + 1;
  localparam int VB   = $bits(gcai_pkg::vec_t);
  localparam int PB   = $bits(gcai_pkg::pvec_t);
  localparam logic [NW1-1:0] ONE_N = NW1'(1) << gcai_pkg::FRAC_BITS;

  logic [NW1-1:0]       n_t, n_h, d_t, d_h;
  logic [2*VB-1:0]      ep_d, ep_dd;
  gcai_pkg::vec_t       tail_d, head_d, tail_dd, head_dd, tail_q, head_q;
  gcai_pkg::vec_t       tail_u, head_u;
  logic                 keep_t, keep_h, bad_t, bad_h;
  logic [2:0]           fl_d;
  logic                 bad_ep, bad_ep_d, short_p;
  gcai_pkg::pvec_t      p_raw, p_raw_d;
  logic [PW1-1:0]       n_p;
  logic [2*VB-1:0]      unit_d;

  // Endpoint norms
  gcai_norm #(.CW(CW)) u_norm_t (.clk(clk), .en(en), .v(tail), .norm(n_t));
  gcai_norm #(.CW(CW)) u_norm_h (.clk(clk), .en(en), .v(head), .norm(n_h));

  gcai_dly #(.W(2*VB), .N(gcai_pkg::NORM_LAT_C)) u_dly_ep (
    .clk(clk), .en(en), .d({tail, head}), .q(ep_d)
  );
  assign tail_d = ep_d[2*VB-1:VB];
  assign head_d = ep_d[VB-1:0];

  // Classify each endpoint against epsilon
  assign d_t    = (n_t > ONE_N) ? n_t - ONE_N : ONE_N - n_t;
  assign d_h    = (n_h > ONE_N) ? n_h - ONE_N : ONE_N - n_h;
  assign keep_t = d_t <= NW1'(eps);
  assign keep_h = d_h <= NW1'(eps);
  assign bad_t  = !keep_t && (n_t <= NW1'(eps));
  assign bad_h  = !keep_h && (n_h <= NW1'(eps));

  // Rescale endpoints to unit length
  for (genvar i = 0; i < 3; i++) begin : g_ep_div
    gcai_div #(.NW(CW), .DW(NW1)) u_div_t (
      .clk(clk), .en(en), .num(tail_d[i]), .den(n_t), .quo(tail_q[i])
    );
    gcai_div #(.NW(CW), .DW(NW1)) u_div_h (
      .clk(clk), .en(en), .num(head_d[i]), .den(n_h), .quo(head_q[i])
    );
  end

  gcai_dly #(.W(3), .N(gcai_pkg::DIV_LAT)) u_dly_fl (
    .clk(clk), .en(en), .d({keep_t, keep_h, bad_t | bad_h}), .q(fl_d)
  );
  gcai_dly #(.W(2*VB), .N(gcai_pkg::DIV_LAT)) u_dly_ep2 (
    .clk(clk), .en(en), .d(ep_d), .q(ep_dd)
  );
  assign tail_dd = ep_dd[2*VB-1:VB];
  assign head_dd = ep_dd[VB-1:0];

  // Pick the original or rescaled endpoint
  always_ff @(posedge clk) begin
    if (en) begin
      tail_u <= fl_d[2] ? tail_dd : tail_q;
      head_u <= fl_d[1] ? head_dd : head_q;
      bad_ep <= fl_d[0];
    end
  end

  // Pole: cross product of the unit endpoints
  gcai_cross u_cross (.clk(clk), .en(en), .a(tail_u), .b(head_u), .p(p_raw));

  gcai_norm #(.CW(PW)) u_norm_p (.clk(clk), .en(en), .v(p_raw), .norm(n_p));

  gcai_dly #(.W(PB), .N(gcai_pkg::NORM_LAT_P)) u_dly_p (
    .clk(clk), .en(en), .d(p_raw), .q(p_raw_d)
  );
  gcai_dly #(.W(1), .N(gcai_pkg::CROSS_LAT + gcai_pkg::NORM_LAT_P)) u_dly_bad (
    .clk(clk), .en(en), .d(bad_ep), .q(bad_ep_d)
  );

  assign short_p = (n_p < PW1'(eps)) || (n_p == '0);

  for (genvar i = 0; i < 3; i++) begin : g_pole_div
    gcai_div #(.NW(PW), .DW(PW1)) u_div_p (
      .clk(clk), .en(en), .num(p_raw_d[i]), .den(n_p), .quo(pole[i])
    );
  end

  gcai_dly #(.W(1), .N(gcai_pkg::DIV_LAT)) u_dly_badf (
    .clk(clk), .en(en), .d(bad_ep_d | short_p), .q(bad)
  );

  // Hold unit endpoints until the pole is ready
  gcai_dly #(.W(2*VB),
             .N(gcai_pkg::CROSS_LAT + gcai_pkg::NORM_LAT_P + gcai_pkg::DIV_LAT)) u_dly_u (
    .clk(clk), .en(en), .d({tail_u, head_u}), .q(unit_d)
  );
  assign tail_unit = unit_d[2*VB-1:VB];
  assign head_unit = unit_d[VB-1:0];

endmodule
`default_nettype wire

FILE: sv/great_circle_arc_intersect.sv
// Throughput: one arc pair per cycle; the pipeline moves whenever the output register
// is empty or being taken, so a stall at the result side holds every stage.
// The depth is set by the bit-per-stage square root and divider units.
// Reset (rst, synchronous, active high) empties the pipeline and sets epsilon to 2.
`default_nettype none
module great_circle_arc_intersect (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  gcai_pkg::req_t                  req_data,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output gcai_pkg::rsp_t                  rsp_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gcai_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int CW   = gcai_pkg::CW;
  localparam int PW   = gcai_pkg::PW;
  localparam int PW1  = PW + 1;
  localparam int SQ   = 2 * CW;
  localparam int DOTW = gcai_pkg::DOTW;
  localparam int LAT  = gcai_pkg::TOP_LAT;
  localparam int VB   = $bits(gcai_pkg::vec_t);
  localparam int PB   = $bits(gcai_pkg::pvec_t);
  localparam int EW   = gcai_pkg::EPS_W;
  localparam logic signed [CW-1:0] ONE_S = CW'(1) << gcai_pkg::FRAC_BITS;

  logic [EW-1:0]     eps;
  logic [LAT-1:0]    vld;
  logic              en;

  gcai_pkg::vec_t    tail_a, head_a, tail_b, head_b;
  gcai_pkg::vec_t    tu_a, hu_a, tu_b, hu_b, pole_a, pole_b;
  logic              bad_a, bad_b, bad_d;
  gcai_pkg::pvec_t   w_raw, w_raw_d;
  logic [PW1-1:0]    n_w;
  logic              coll;
  gcai_pkg::status_t st_c;
  logic [1:0]        st_fin;
  gcai_pkg::vec_t    pt, pt_d, ta_d;

  gcai_pkg::vec_t    cx_l [0:3];
  gcai_pkg::vec_t    cx_r [0:3];
  logic signed [SQ-1:0]   cx_prod [0:3][0:2];
  logic signed [DOTW-1:0] cx_dot  [0:3];
  logic              cx_flag, cx_fin;

  logic signed [SQ-1:0] sd_prod [0:2];
  logic              sd_pos;

  gcai_pkg::rsp_t    rsp_q;

  // Configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= gcai_pkg::EPS_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[gcai_pkg::ADDR_W-1:2] == gcai_pkg::REG_EPSILON) begin
      eps <= pwdata[EW-1:0];
    end
  end
  assign prdata = (paddr[gcai_pkg::ADDR_W-1:2] == gcai_pkg::REG_EPSILON) ? 32'(eps) : '0;

  // Pipeline flow: advance unless the output word is stalled
  assign en        = !vld[LAT-1] || rsp_ready;
  assign req_ready = en;
  assign rsp_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], req_valid};
    end
  end

  assign tail_a = {req_data.a_tail_z, req_data.a_tail_y, req_data.a_tail_x};
  assign head_a = {req_data.a_head_z, req_data.a_head_y, req_data.a_head_x};
  assign tail_b = {req_data.b_tail_z, req_data.b_tail_y, req_data.b_tail_x};
  assign head_b = {req_data.b_head_z, req_data.b_head_y, req_data.b_head_x};

  // Per-arc unit endpoints and poles
  gcai_arc u_arc_a (
    .clk(clk), .en(en), .eps(eps), .tail(tail_a), .head(head_a),
    .tail_unit(tu_a), .head_unit(hu_a), .pole(pole_a), .bad(bad_a)
  );
  gcai_arc u_arc_b (
    .clk(clk), .en(en), .eps(eps), .tail(tail_b), .head(head_b),
    .tail_unit(tu_b), .head_unit(hu_b), .pole(pole_b), .bad(bad_b)
  );

  // Intersection direction: cross product of the poles
  gcai_cross u_cross_w (.clk(clk), .en(en), .a(pole_a), .b(pole_b), .p(w_raw));
  gcai_norm #(.CW(PW)) u_norm_w (.clk(clk), .en(en), .v(w_raw), .norm(n_w));
  gcai_dly #(.W(PB), .N(gcai_pkg::NORM_LAT_P)) u_dly_w (
    .clk(clk), .en(en), .d(w_raw), .q(w_raw_d)
  );

  for (genvar i = 0; i < 3; i++) begin : g_w_div
    gcai_div #(.NW(PW), .DW(PW1)) u_div_w (
      .clk(clk), .en(en), .num(w_raw_d[i]), .den(n_w), .quo(pt[i])
    );
  end

  // Status
  gcai_dly #(.W(1), .N(gcai_pkg::CROSS_LAT + gcai_pkg::NORM_LAT_P)) u_dly_bad (
    .clk(clk), .en(en), .d(bad_a | bad_b), .q(bad_d)
  );
  assign coll = (n_w < PW1'(eps)) || (n_w == '0);

  always_comb begin
    if (bad_d) begin
      st_c = gcai_pkg::ST_MALFORMED;
    end else if (coll) begin
      st_c = gcai_pkg::ST_COLLINEAR;
    end else begin
      st_c = gcai_pkg::ST_OK;
    end
  end

  gcai_dly #(.W(2), .N(gcai_pkg::DIV_LAT + gcai_pkg::SGN_LAT)) u_dly_st (
    .clk(clk), .en(en), .d(st_c), .q(st_fin)
  );

  // Crossing test: sign products of four dot products
  assign cx_l = '{tu_a, hu_a, pole_a, pole_a};
  assign cx_r = '{pole_b, pole_b, tu_b, hu_b};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 3; j++) begin
          cx_prod[i][j] <= SQ'($signed(cx_l[i][j])) * SQ'($signed(cx_r[i][j]));
        end
        cx_dot[i] <= DOTW'(cx_prod[i][0]) + DOTW'(cx_prod[i][1]) + DOTW'(cx_prod[i][2]);
      end
      cx_flag <= gcai_pkg::opp(cx_dot[0], cx_dot[1]) && gcai_pkg::opp(cx_dot[2], cx_dot[3]);
    end
  end

  gcai_dly #(.W(1), .N(gcai_pkg::CROSS_LAT + gcai_pkg::NORM_LAT_P + gcai_pkg::DIV_LAT
                      + gcai_pkg::SGN_LAT - gcai_pkg::CXF_LAT)) u_dly_cx (
    .clk(clk), .en(en), .d(cx_flag), .q(cx_fin)
  );

  // Side test against the first tail
  gcai_dly #(.W(VB), .N(gcai_pkg::CROSS_LAT + gcai_pkg::NORM_LAT_P + gcai_pkg::DIV_LAT)) u_dly_ta (
    .clk(clk), .en(en), .d(tu_a), .q(ta_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        sd_prod[j] <= SQ'($signed(ta_d[j])) * SQ'($signed(pt[j]));
      end
      sd_pos <= (DOTW'(sd_prod[0]) + DOTW'(sd_prod[1]) + DOTW'(sd_prod[2])) > 0;
    end
  end

  gcai_dly #(.W(VB), .N(gcai_pkg::SGN_LAT)) u_dly_pt (
    .clk(clk), .en(en), .d(pt), .q(pt_d)
  );

  // Output word
  always_ff @(posedge clk) begin
    if (en) begin
      rsp_q.status <= gcai_pkg::status_t'(st_fin);
      if (st_fin == gcai_pkg::ST_OK) begin
        rsp_q.point_x    <= sd_pos ? $signed(pt_d[0]) : -$signed(pt_d[0]);
        rsp_q.point_y    <= sd_pos ? $signed(pt_d[1]) : -$signed(pt_d[1]);
        rsp_q.point_z    <= sd_pos ? $signed(pt_d[2]) : -$signed(pt_d[2]);
        rsp_q.arcs_cross <= cx_fin;
      end else begin
        rsp_q.point_x    <= '0;
        rsp_q.point_y    <= '0;
        rsp_q.point_z    <= '0;
        rsp_q.arcs_cross <= 1'b0;
      end
    end
  end

  assign rsp_data = rsp_q;

  // Error words carry a zero point and no crossing
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status != gcai_pkg::ST_OK |->
      rsp_data.point_x == 0 && rsp_data.point_y == 0 && rsp_data.point_z == 0
      && !rsp_data.arcs_cross)
    else $error("error word with nonzero payload");

  // A good point stays within unit range
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.status == gcai_pkg::ST_OK |->
      rsp_data.point_x <= ONE_S && rsp_data.point_x >= -ONE_S
      && rsp_data.point_y <= ONE_S && rsp_data.point_y >= -ONE_S
      && rsp_data.point_z <= ONE_S && rsp_data.point_z >= -ONE_S)
    else $error("point component out of unit range");

  // A word one stage from the end reaches the output on the next move
  a_last_stage: assert property (@(posedge clk) disable iff (rst)
    en && vld[LAT-2] |=> rsp_valid)
    else $error("word lost at output stage");

  // Nothing reaches the output without a word behind it
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    en && !vld[LAT-2] |=> !rsp_valid)
    else $error("output word without source");

endmodule
`default_nettype wire
